// ===== rtl/are_pkg.sv =====
`default_nettype none
package are_pkg;

	localparam int MODEL_SIZE_DEF = 256;
	localparam int ALPHA_W = 9;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd256;
	localparam logic [63:0] COUNT_LIMIT = 64'h0100_0000_0000_0000;

	localparam logic [1:0] KIND_ENCODE  = 2'd0;
	localparam logic [1:0] KIND_FLUSH   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       error;
	} out_word_t;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/are_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module are_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire are_pkg::div_req_t req,
	output are_pkg::div_rsp_t     rsp
);
	import are_pkg::*;

	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [64:0] trial;
	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	// iterate over the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/adaptive_range_encoder.sv =====
`default_nettype none
// adaptive range encoder with a fenwick-tree frequency model
// in: valid/ready channel, word = {kind, symbol}; kind 0 encodes a symbol,
// 1 flushes eight bytes, 2 restarts coder and model
// out: valid/ready channel, word = {out_byte, last, error}; last marks the
// final byte of an item, error flags a symbol with zero count or out of range
// cfg: cfg_we/cfg_wdata write alphabet_size, used at the next restart
// one item at a time. after reset and after every restart a sweep over
// every entry rebuilds the count and tree memories; no item is taken.
// encode: one count read, tree reads for the total and then the start,
// a division by the total, six 32x32 partial products, one update step
// and a tree update walk; then the emitted bytes, one per cycle while
// the receiver takes them, a setup step and a byte pair on underflow,
// else a final step back to idle. flush: eight bytes.
// the divider sets the bulk of the time.
// a stalled receiver holds the current byte; the block waits on it.
module adaptive_range_encoder #(
	parameter int MODEL_SIZE = are_pkg::MODEL_SIZE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire are_pkg::in_word_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output are_pkg::out_word_t                out_data,
	input  wire logic                         cfg_we,
	input  wire logic [are_pkg::ALPHA_W-1:0]  cfg_wdata
);
	import are_pkg::*;

	localparam int AW = (MODEL_SIZE > 1) ? $clog2(MODEL_SIZE) : 1;
	localparam int KW = AW + 1;
	localparam logic [KW-1:0] MSZ = KW'(MODEL_SIZE);

	typedef enum logic [10:0] {
		ST_CLEAR  = 11'b00000000001,
		ST_IDLE   = 11'b00000000010,
		ST_CNT    = 11'b00000000100,
		ST_SUM    = 11'b00000001000,
		ST_DIV    = 11'b00000010000,
		ST_MUL1   = 11'b00000100000,
		ST_MUL2   = 11'b00001000000,
		ST_BUMP   = 11'b00010000000,
		ST_EMIT   = 11'b00100000000,
		ST_ERR    = 11'b01000000000,
		ST_BUILD  = 11'b10000000000
	} state_t;

	state_t state_q;

	// memories
	logic [56:0] cnt_mem [MODEL_SIZE];
	logic [63:0] tree_mem [MODEL_SIZE];
	logic [56:0] cnt_rd_q;
	logic [63:0] tree_rd_q;
	logic [AW-1:0] tree_ra;
	logic [AW-1:0] tree_wa;
	logic          tree_we;
	logic [63:0]   tree_wd;
	logic [AW-1:0] cnt_ra;
	logic          cnt_we;
	logic [AW-1:0] cnt_wa;
	logic [56:0]   cnt_wd;

	always_ff @(posedge clk) begin
		if (tree_we) begin
			tree_mem[tree_wa] <= tree_wd;
		end
		tree_rd_q <= tree_mem[tree_ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	logic [ALPHA_W-1:0] alpha_q;
	logic [63:0] low_q, range_q, total_q, start_q, size_q, prod_q, rprod_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] sym_q;
	logic [1:0]    phase_q;      // sum: 0 total, 1 start
	logic          rd_pend_q;
	logic [2:0]    mstep_q;
	logic [3:0]    loops_q;
	logic          under_q;
	logic [1:0]    under_left_q;
	logic          is_flush_q;
	logic [3:0]    flush_left_q;
	logic          bump_q;
	logic          out_valid_q;
	out_word_t     out_q;
	div_req_t      dreq;
	div_rsp_t      drsp;

	are_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	function automatic logic [KW-1:0] lowbit(input logic [KW-1:0] k);
		return k & (~k + KW'(1));
	endfunction

	// fenwick init weight of node k (1-based): counts of symbols k-lowbit+1..k
	logic [KW-1:0] lb;
	logic [KW-1:0] hi_k, lo_k, lim;
	logic [KW:0]   ones;
	always_comb begin
		lb   = lowbit(k_q);
		hi_k = k_q;
		lim  = (alpha_q > ALPHA_W'(MODEL_SIZE)) ? MSZ : KW'(alpha_q);
		lo_k = k_q - lb;
		if (lim <= lo_k)      ones = '0;
		else if (lim >= hi_k) ones = {1'b0, lb};
		else                  ones = {1'b0, lim - lo_k};
	end

	// shared 32x32 multiplier, one partial product per cycle
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	always_comb begin
		case (mstep_q)
			3'd0: begin
				mul_a = start_q[31:0];
				mul_b = range_q[31:0];
			end
			3'd1: begin
				mul_a = start_q[63:32];
				mul_b = range_q[31:0];
			end
			3'd2: begin
				mul_a = start_q[31:0];
				mul_b = range_q[63:32];
			end
			3'd3: begin
				mul_a = range_q[31:0];
				mul_b = size_q[31:0];
			end
			3'd4: begin
				mul_a = range_q[63:32];
				mul_b = size_q[31:0];
			end
			3'd5: begin
				mul_a = range_q[31:0];
				mul_b = size_q[63:32];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	logic        agree;
	logic [63:0] sum_lr;
	assign sum_lr = low_q + range_q;
	assign agree  = (low_q[63:56] == sum_lr[63:56]);

	// look ahead: does another byte follow the one being emitted
	logic [63:0] low_n, range_n, sum_n;
	logic        more_n;
	assign low_n   = {low_q[55:0], 8'd0};
	assign range_n = {range_q[55:0], 8'd0};
	assign sum_n   = low_n + range_n;
	assign more_n  = ((loops_q < 4'd7) && (low_n[63:56] == sum_n[63:56])) ||
		(range_n < total_q + 64'd1);

	logic sym_ok;
	assign sym_ok = ({1'b0, in_data.symbol} < 9'(MODEL_SIZE));

	// a new output word is loaded this cycle
	logic out_load;
	always_comb begin
		out_load = 1'b0;
		case (state_q)
			ST_EMIT: begin
				out_load = (!out_valid_q || out_ready) &&
					(is_flush_q || under_q || (loops_q < 4'd8 && agree));
			end
			ST_ERR: begin
				out_load = !out_valid_q;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		tree_ra = k_q[AW-1:0] - AW'(1);
		cnt_ra  = in_data.symbol[AW-1:0];
		tree_we = 1'b0;
		tree_wa = k_q[AW-1:0] - AW'(1);
		tree_wd = tree_rd_q + 64'd1;
		cnt_we  = 1'b0;
		cnt_wa  = k_q[AW-1:0] - AW'(1);
		cnt_wd  = (KW'(cnt_wa) < lim) ? 57'd1 : 57'd0;
		dreq.start    = 1'b0;
		dreq.dividend = range_q;
		dreq.divisor  = total_q;
		case (state_q)
			ST_CLEAR, ST_BUILD: begin
				tree_we = 1'b1;
				tree_wd = {{(63-KW){1'b0}}, ones};
				cnt_we  = 1'b1;
			end
			ST_SUM: begin
				if (k_q == '0 && !rd_pend_q && phase_q == 2'd1) begin
					dreq.start = 1'b1;
				end
			end
			ST_BUMP: begin
				tree_we = rd_pend_q && bump_q;
				cnt_we  = 1'b0;
			end
			ST_MUL2: begin
				cnt_we = bump_q;
				cnt_wa = sym_q;
				cnt_wd = size_q[56:0] + 57'd1;
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			alpha_q     <= ALPHA_RESET;
			k_q         <= KW'(1);
			low_q       <= '0;
			range_q     <= '1;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
			phase_q     <= '0;
			mstep_q     <= '0;
			loops_q     <= '0;
			under_q     <= 1'b0;
			under_left_q <= '0;
			is_flush_q  <= 1'b0;
			flush_left_q <= '0;
			bump_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR, ST_BUILD: begin
					if (k_q == MSZ) begin
						state_q <= ST_IDLE;
					end
					k_q <= k_q + KW'(1);
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						case (in_data.kind)
							KIND_RESTART: begin
								low_q   <= '0;
								range_q <= '1;
								k_q     <= KW'(1);
								state_q <= ST_BUILD;
							end
							KIND_FLUSH: begin
								is_flush_q   <= 1'b1;
								flush_left_q <= 4'd8;
								state_q      <= ST_EMIT;
							end
							KIND_ENCODE: begin
								sym_q <= in_data.symbol[AW-1:0];
								if (!sym_ok) state_q <= ST_ERR;
								else state_q <= ST_CNT;
							end
							default: ;
						endcase
					end
				end
				ST_CNT: begin
					// count read lands this cycle
					size_q    <= {7'd0, cnt_rd_q};
					if (cnt_rd_q == '0) begin
						state_q <= ST_ERR;
					end else begin
						state_q   <= ST_SUM;
						phase_q   <= 2'd0;
						total_q   <= '0;
						k_q       <= MSZ;
						rd_pend_q <= 1'b0;
					end
				end
				ST_SUM: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						if (phase_q == 2'd0) total_q <= total_q + tree_rd_q;
						else start_q <= start_q + tree_rd_q;
						k_q <= k_q - lowbit(k_q);
					end else if (k_q != '0) begin
						rd_pend_q <= 1'b1;
					end else if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
						start_q <= '0;
						k_q     <= {1'b0, sym_q};
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						range_q <= drsp.quotient;
						mstep_q <= '0;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					// start * range, then range * size, low 64 bits of each
					if (mstep_q == 3'd0) begin
						prod_q <= mul_p;
					end else if (mstep_q < 3'd3) begin
						prod_q <= prod_q + {mul_p[31:0], 32'd0};
					end else if (mstep_q == 3'd3) begin
						rprod_q <= mul_p;
					end else begin
						rprod_q <= rprod_q + {mul_p[31:0], 32'd0};
					end
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd5) begin
						bump_q  <= (total_q < COUNT_LIMIT);
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					low_q     <= low_q + prod_q;
					range_q   <= rprod_q;
					k_q       <= {1'b0, sym_q} + KW'(1);
					rd_pend_q <= 1'b0;
					state_q   <= ST_BUMP;
				end
				ST_BUMP: begin
					if (!bump_q || k_q > MSZ || k_q == '0) begin
						loops_q    <= '0;
						under_q    <= 1'b0;
						is_flush_q <= 1'b0;
						state_q    <= ST_EMIT;
					end else if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						k_q <= k_q + lowbit(k_q);
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						if (is_flush_q) begin
							out_q <= '{out_byte: low_q[63:56],
								last: (flush_left_q == 4'd1), error: 1'b0};
							low_q   <= {low_q[55:0], 8'd0};
							range_q <= {{56{1'b1}}, 8'd0};
							flush_left_q <= flush_left_q - 4'd1;
							if (flush_left_q == 4'd1) begin
								is_flush_q <= 1'b0;
								state_q    <= ST_IDLE;
							end
						end else if (under_q) begin
							out_q <= '{out_byte: low_q[63:56],
								last: (under_left_q == 2'd1), error: 1'b0};
							low_q <= {low_q[55:0], 8'd0};
							under_left_q <= under_left_q - 2'd1;
							if (under_left_q == 2'd1) begin
								range_q <= 64'hFFFF_FFFF_FFFF_FFFF - {low_q[55:0], 8'd0};
								state_q <= ST_IDLE;
							end
						end else if (loops_q < 4'd8 && agree) begin
							// last only if no further byte follows
							out_q.out_byte <= low_q[63:56];
							out_q.error    <= 1'b0;
							out_q.last     <= !more_n;
							low_q   <= {low_q[55:0], 8'd0};
							range_q <= {range_q[55:0], 8'd0};
							loops_q <= loops_q + 4'd1;
						end else if (range_q < total_q + 64'd1) begin
							under_q      <= 1'b1;
							under_left_q <= 2'd2;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (!out_valid_q) begin
						out_q <= '{out_byte: 8'd0, last: 1'b1, error: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import are_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int N_SYM = 256;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;
	logic cfg_we;
	logic [ALPHA_W-1:0] cfg_wdata;

	// coder state as the block should hold it
	logic [63:0] coder_low;
	logic [63:0] coder_range;
	logic [63:0] sym_count [N_SYM];
	logic [ALPHA_W-1:0] alpha_size;

	out_word_t pending_bytes [$];
	int mismatches;
	int words_sent;
	int bytes_seen;
	int errors_seen;
	int hold_left;
	bit idle_free;

	adaptive_range_encoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report(input string what);
		mismatches++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	// rebuild the frequency model from the alphabet size
	task automatic model_restart();
		coder_low = '0;
		coder_range = '1;
		for (int k = 0; k < N_SYM; k++)
			sym_count[k] = (k < int'(alpha_size)) ? 64'd1 : 64'd0;
	endtask

	task automatic push_top(ref out_word_t q[$]);
		q.push_back('{out_byte: coder_low[63:56], last: 1'b0, error: 1'b0});
		coder_low = coder_low << 8;
		coder_range = coder_range << 8;
	endtask

	// expected output bytes for one accepted word
	task automatic predict_bytes(input in_word_t w);
		out_word_t q [$];
		logic [63:0] total;
		logic [63:0] start;
		logic [63:0] size;
		int loops;
		total = '0;
		start = '0;
		loops = 0;
		case (w.kind)
			KIND_RESTART: begin
				model_restart();
			end
			KIND_FLUSH: begin
				for (int k = 0; k < 8; k++) begin
					coder_range = '1;
					push_top(q);
				end
			end
			KIND_ENCODE: begin
				if (sym_count[w.symbol] == 0) begin
					q.push_back('{out_byte: 8'h00, last: 1'b0, error: 1'b1});
				end else begin
					size = sym_count[w.symbol];
					for (int k = 0; k < N_SYM; k++) begin
						total += sym_count[k];
						if (k < int'(w.symbol))
							start += sym_count[k];
					end
					coder_range = coder_range / total;
					coder_low = coder_low + start * coder_range;
					coder_range = coder_range * size;
					if (total < COUNT_LIMIT)
						sym_count[w.symbol] = sym_count[w.symbol] + 1;
					while (loops < 8 &&
						coder_low[63:56] == ((coder_low + coder_range) >> 56)) begin
						push_top(q);
						loops++;
					end
					if (coder_range < total + 1) begin
						push_top(q);
						push_top(q);
						coder_range = 64'hFFFF_FFFF_FFFF_FFFF - coder_low;
					end
				end
			end
			default: ;
		endcase
		if (q.size() > 0)
			q[q.size()-1].last = 1'b1;
		foreach (q[i])
			pending_bytes.push_back(q[i]);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (idle_free || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one word and wait until it is taken
	task automatic send_word(input logic [1:0] kind, input logic [7:0] sym);
		int gap;
		bit ok;
		in_word_t w;
		w.kind = kind;
		w.symbol = sym;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		predict_bytes(w);
		words_sent++;
	endtask

	// wait for every expected byte, then let a restart sweep finish
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_alphabet(input logic [ALPHA_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		alpha_size = v;
	endtask

	// receiver side: random stalls plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (idle_free) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 70) ||
				($urandom_range(0, 99) < 50);
		end
	end

	// compare each taken byte with the oldest expectation
	always @(negedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			bytes_seen++;
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected word %h", out_data));
			end else begin
				want = pending_bytes.pop_front();
				if (out_data.error)
					errors_seen++;
				if (out_data.out_byte !== want.out_byte)
					report($sformatf("out_byte %h want %h", out_data.out_byte,
						want.out_byte));
				if (out_data.last !== want.last)
					report($sformatf("last %b want %b", out_data.last, want.last));
				if (out_data.error !== want.error)
					report($sformatf("error %b want %b", out_data.error, want.error));
			end
		end
	end

	// field extremes, every kind, repeated symbols
	task automatic test_directed();
		send_word(KIND_ENCODE, 8'd0);
		send_word(KIND_ENCODE, 8'd255);
		send_word(KIND_ENCODE, 8'd128);
		send_word(KIND_FLUSH, 8'hFF);
		send_word(KIND_UNUSED, 8'hAA);
		send_word(KIND_RESTART, 8'h55);
		for (int k = 0; k < 10; k++)
			send_word(KIND_ENCODE, 8'd7);
		send_word(KIND_FLUSH, 8'd0);
		send_word(KIND_ENCODE, 8'd255);
	endtask

	// alphabet sizes: two, zero, above model size, full
	task automatic test_alphabet();
		write_alphabet(9'd2);
		send_word(KIND_RESTART, 8'd0);
		send_word(KIND_ENCODE, 8'd0);
		send_word(KIND_ENCODE, 8'd1);
		send_word(KIND_ENCODE, 8'd5);
		send_word(KIND_ENCODE, 8'd255);
		send_word(KIND_FLUSH, 8'd0);
		write_alphabet(9'd0);
		send_word(KIND_RESTART, 8'd0);
		send_word(KIND_ENCODE, 8'd0);
		write_alphabet(9'd511);
		send_word(KIND_RESTART, 8'd0);
		send_word(KIND_ENCODE, 8'd255);
		write_alphabet(9'd256);
		send_word(KIND_RESTART, 8'd0);
	endtask

	// receiver stalls for a long stretch while words keep coming
	task automatic test_backpressure();
		hold_left = 300;
		for (int k = 0; k < 4; k++)
			send_word(KIND_FLUSH, 8'd0);
		send_word(KIND_ENCODE, 8'd3);
		send_word(KIND_ENCODE, 8'd3);
		wait_drained();
		send_word(KIND_ENCODE, 8'd9);
	endtask

	// mostly encodes on a few hot symbols, some flushes, restarts and unused kinds, with alphabet changes
	task automatic test_random(input int count);
		logic [7:0] sym;
		int r;
		for (int n = 0; n < count; n++) begin
			if (n % 60 == 59) begin
				write_alphabet((n % 120 == 59) ? 9'($urandom_range(2, 40)) :
					9'($urandom_range(0, 511)));
				send_word(KIND_RESTART, 8'($urandom));
			end
			idle_free = (n % 100) > 80;
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0)
				sym = 8'($urandom);
			else
				sym = 8'($urandom_range(0, 3));
			if (r < 84)
				send_word(KIND_ENCODE, sym);
			else if (r < 93)
				send_word(KIND_FLUSH, 8'($urandom));
			else if (r < 97)
				send_word(KIND_RESTART, 8'($urandom));
			else
				send_word(KIND_UNUSED, 8'($urandom));
		end
		idle_free = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_left = 0;
		idle_free = 1'b0;
		mismatches = 0;
		words_sent = 0;
		bytes_seen = 0;
		errors_seen = 0;
		alpha_size = ALPHA_RESET;
		model_restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_alphabet();
		test_backpressure();
		test_random(230);

		wait_drained();
		$display("sent %0d words (encode, flush, restart, unused kind) over several alphabets",
			words_sent);
		$display("checked %0d output words, %0d of them zero-count errors",
			bytes_seen, errors_seen);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
